// ----- design/cah_pkg.sv -----
// Shared types and constants for the cellular automaton hash unit.
// No dependencies; the top level, cah_ctrl and cah_dp use this package by scoped name.
package cah_pkg;

	localparam int CELLS       = 256;
	localparam int BLOCK_BYTES = 32;
	localparam int LEN_FIELD   = 64;

	// round constants
	localparam logic [7:0] RULE_STEP     = 8'd37;
	localparam logic [7:0] MIX_MUL_BLOCK = 8'd7;
	localparam logic [7:0] MIX_OFF_BLOCK = 8'd13;
	localparam logic [7:0] MIX_MUL_FINAL = 8'd5;
	localparam logic [7:0] MIX_OFF_FINAL = 8'd11;
	localparam logic [7:0] FINAL_ROUNDS  = 8'd10;

	// last byte position that still leaves room for the length field
	localparam logic [4:0] PAD_LAST_POS = 5'd23;
	localparam logic [4:0] BLOCK_LAST_POS = 5'd31;

	// register indexes on the configuration port
	localparam logic REG_RULE   = 1'b0;
	localparam logic REG_ROUNDS = 1'b1;

	// block selection for an absorb
	localparam logic [1:0] ABS_NONE = 2'd0;
	localparam logic [1:0] ABS_BUF  = 2'd1;
	localparam logic [1:0] ABS_PAD  = 2'd2;
	localparam logic [1:0] ABS_LEN  = 2'd3;

	typedef struct packed {
		logic       take_byte;
		logic [1:0] absorb;
		logic       round_en;
		logic       final_mode;
		logic [7:0] rnd;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic pos_last;
		logic pad_split;
		logic out_busy;
	} stat_t;

endpackage

// ----- design/cellular_automaton_hash_256_unit.sv -----
// Top level of the cellular automaton hash: APB registers, sequencer and datapath.
// Depends on cah_pkg, cah_ctrl and cah_dp.
//
//   channel   direction  handshake           payload
//   in        sink       in_valid/in_ready   data_byte, byte_valid, message_end
//   out       source     out_valid/out_ready digest_word, word_last
//   cfg       APB slave  psel/penable/pready rule @0x0, round_count @0x4
//
// An item without message_end is taken in the idle state; the byte that fills a block adds
// an absorb and round_count rounds, one round per cycle on
// a single 256-cell round unit. message_end adds an absorb and the rounds for the padded
// block, another absorb and its rounds when the length spills into a second block,
// 10 finalization rounds and a load of the digest register.
// Reset clears the cell ring, bit count and byte position; rule is 110 and
// round_count 10. A stalled output holds its word; input is blocked whenever the sequencer
// is not idle, also while a new digest waits for the previous one to leave.
module cellular_automaton_hash_256_unit #(
	parameter int LENGTH_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        message_end,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic        word_last,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]     rule_q, rounds_q;
	logic           cfg_wr;
	cah_pkg::cmd_t  cmd;
	cah_pkg::stat_t stat;

	// register file: word-aligned, address bit 2 picks the register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {24'd0, (paddr[2] == cah_pkg::REG_ROUNDS) ? rounds_q : rule_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q   <= 8'd110;
			rounds_q <= 8'd10;
		end else if (cfg_wr) begin
			if (paddr[2] == cah_pkg::REG_RULE) rule_q <= pwdata[7:0];
			else rounds_q <= pwdata[7:0];
		end
	end

	// sequencer: accepts a transfer only when idle, then steps absorbs and rounds
	cah_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.byte_valid  (byte_valid),
		.message_end (message_end),
		.round_count (rounds_q),
		.stat        (stat),
		.cmd         (cmd)
	);

	// datapath: ring state, block buffer, bit count and digest register
	cah_dp #(
		.LEN_W (LENGTH_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.data_byte   (data_byte),
		.rule        (rule_q),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.digest_word (digest_word),
		.word_last   (word_last)
	);

endmodule

// ----- design/cah_ctrl.sv -----
// Sequencer for the cellular automaton hash: byte intake, absorbs, rounds, digest.
// Uses cah_pkg for command and status types.
module cah_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               byte_valid,
	input  logic               message_end,
	input  logic [7:0]         round_count,
	input  cah_pkg::stat_t     stat,
	output cah_pkg::cmd_t      cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ABSORB = 3'd1;
	localparam logic [2:0] S_PAD    = 3'd2;
	localparam logic [2:0] S_LEN    = 3'd3;
	localparam logic [2:0] S_ROUND  = 3'd4;
	localparam logic [2:0] S_FINAL  = 3'd5;
	localparam logic [2:0] S_DIGEST = 3'd6;

	// what follows the rounds of the current block
	localparam logic [1:0] K_FULL = 2'd0;
	localparam logic [1:0] K_PADA = 2'd1;
	localparam logic [1:0] K_PADZ = 2'd2;

	logic [2:0] state_q, state_d;
	logic [1:0] kind_q, kind_d;
	logic [7:0] rnd_q, rnd_d;
	logic       end_q, end_d;
	logic [2:0] after_st;

	// destination once the rounds of a block are done
	always_comb begin
		case (kind_d)
			K_FULL:  after_st = end_d ? S_PAD : S_IDLE;
			K_PADA:  after_st = S_LEN;
			K_PADZ:  after_st = S_FINAL;
			default: after_st = S_IDLE;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		rnd_d    = rnd_q;
		end_d    = end_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.rnd  = rnd_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					end_d         = message_end;
					cmd.take_byte = byte_valid;
					if (byte_valid && stat.pos_last) begin
						state_d = S_ABSORB;
					end else if (message_end) begin
						state_d = S_PAD;
					end
				end
			end
			S_ABSORB, S_PAD, S_LEN: begin
				case (state_q)
					S_ABSORB: begin
						cmd.absorb = cah_pkg::ABS_BUF;
						kind_d     = K_FULL;
					end
					S_PAD: begin
						cmd.absorb = cah_pkg::ABS_PAD;
						kind_d     = stat.pad_split ? K_PADA : K_PADZ;
					end
					default: begin
						cmd.absorb = cah_pkg::ABS_LEN;
						kind_d     = K_PADZ;
					end
				endcase
				rnd_d   = '0;
				state_d = (round_count == 8'd0) ? after_st : S_ROUND;
			end
			S_ROUND: begin
				cmd.round_en = 1'b1;
				if (rnd_q == round_count - 8'd1) begin
					rnd_d   = '0;
					state_d = after_st;
				end else begin
					rnd_d = rnd_q + 8'd1;
				end
			end
			S_FINAL: begin
				cmd.round_en   = 1'b1;
				cmd.final_mode = 1'b1;
				if (rnd_q == cah_pkg::FINAL_ROUNDS - 8'd1) begin
					rnd_d   = '0;
					state_d = S_DIGEST;
				end else begin
					rnd_d = rnd_q + 8'd1;
				end
			end
			S_DIGEST: begin
				// hold until the previous digest has fully left
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					end_d        = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= K_FULL;
			rnd_q   <= '0;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			rnd_q   <= rnd_d;
			end_q   <= end_d;
		end
	end

endmodule

// ----- design/cah_dp.sv -----
// Datapath of the cellular automaton hash: block buffer, cell ring, round logic,
// length counter and digest output register. Uses cah_pkg.
module cah_dp #(
	parameter int LEN_W = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cah_pkg::cmd_t      cmd,
	output cah_pkg::stat_t     stat,
	input  logic [7:0]         data_byte,
	input  logic [7:0]         rule,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [63:0]        digest_word,
	output logic               word_last
);

	// bit i of every 256-bit vector is cell i of the ring
	logic [255:0]     cell_q, buf_q, dig_q;
	logic [LEN_W-1:0] len_q;
	logic [4:0]       pos_q;
	logic [1:0]       ocnt_q;
	logic             obusy_q;

	logic [7:0]   byte_rev;
	logic [63:0]  len64;
	logic [63:0]  len_cells;
	logic [255:0] pad_blk, blk, mix, nxt;
	logic [511:0] dbl;
	logic [7:0]   off, rl;
	logic         split;
	logic         out_xfer;

	assign split    = pos_q > cah_pkg::PAD_LAST_POS;
	assign len64    = 64'(len_q);
	assign out_xfer = obusy_q && out_ready;

	assign stat.pos_last  = pos_q == cah_pkg::BLOCK_LAST_POS;
	assign stat.pad_split = split;
	assign stat.out_busy  = obusy_q;

	always_comb begin
		for (int j = 0; j < 8; j++) byte_rev[j] = data_byte[7-j];
		for (int j = 0; j < 64; j++) len_cells[j] = len64[63-j];
	end

	// 1 bit after the last byte, zeros, length in the last word if it fits
	always_comb begin
		for (int b = 0; b < cah_pkg::BLOCK_BYTES; b++) begin
			if (5'(b) < pos_q) pad_blk[b*8 +: 8] = buf_q[b*8 +: 8];
			else if (5'(b) == pos_q) pad_blk[b*8 +: 8] = 8'h01;
			else pad_blk[b*8 +: 8] = 8'h00;
		end
		if (!split) pad_blk[255:192] = len_cells;
	end

	always_comb begin
		case (cmd.absorb)
			cah_pkg::ABS_BUF: blk = buf_q;
			cah_pkg::ABS_PAD: blk = pad_blk;
			cah_pkg::ABS_LEN: blk = {len_cells, 192'd0};
			default:          blk = '0;
		endcase
	end

	// one round: rule of each neighbourhood XOR a rotated stride permutation
	always_comb begin
		if (cmd.final_mode) begin
			off = 8'(cmd.rnd * cah_pkg::MIX_OFF_FINAL);
			rl  = rule;
		end else begin
			off = 8'(cmd.rnd * cah_pkg::MIX_OFF_BLOCK);
			rl  = rule + 8'(cmd.rnd * cah_pkg::RULE_STEP);
		end
		dbl = {cell_q, cell_q} >> off;
		for (int i = 0; i < cah_pkg::CELLS; i++) begin
			mix[i] = cmd.final_mode ? dbl[8'(i * cah_pkg::MIX_MUL_FINAL)]
			                        : dbl[8'(i * cah_pkg::MIX_MUL_BLOCK)];
			nxt[i] = rl[{cell_q[8'(i + 255)], cell_q[i], cell_q[8'(i + 1)]}] ^ mix[i];
		end
	end

	always_comb begin
		for (int j = 0; j < 64; j++) digest_word[63-j] = dig_q[{ocnt_q, 6'(j)}];
	end
	assign out_valid = obusy_q;
	assign word_last = ocnt_q == 2'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q  <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			ocnt_q  <= '0;
			obusy_q <= 1'b0;
		end else begin
			if (cmd.take_byte) begin
				len_q <= len_q + LEN_W'(8);
				pos_q <= pos_q + 5'd1;
			end
			if (cmd.absorb != cah_pkg::ABS_NONE) begin
				cell_q <= cell_q ^ blk;
			end else if (cmd.round_en) begin
				cell_q <= nxt;
			end
			if (out_xfer) begin
				ocnt_q <= ocnt_q + 2'd1;
				if (ocnt_q == 2'd3) obusy_q <= 1'b0;
			end
			if (cmd.load_out) begin
				cell_q  <= '0;
				len_q   <= '0;
				pos_q   <= '0;
				ocnt_q  <= '0;
				obusy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) buf_q[{pos_q, 3'b000} +: 8] <= byte_rev;
		if (cmd.load_out) dig_q <= cell_q;
	end

endmodule

// ----- design/cah_checker.sv -----
// Port-level checks for the cellular automaton hash unit, bound to its top level.
// Depends only on the top level's ports.
module cah_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        message_end,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] digest_word,
	input logic        word_last,
	input logic        pready
);

	// a stalled digest word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_last))
		else $error("digest word changed while stalled");

	// the four words leave back to back with a ready sink; none is dropped early
	a_out_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !word_last |=> out_valid)
		else $error("digest ended before its last word");

	// out_valid is low in the cycle after the last word's transfer: no reload without a gap
	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && word_last |=> !out_valid)
		else $error("digest reloaded without a gap");

	// message end starts padding: input blocked and no digest appears at once
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && message_end |=> !in_ready && !$rose(out_valid))
		else $error("message end not followed by padding");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind cellular_automaton_hash_256_unit cah_checker u_cah_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.message_end (message_end),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.digest_word (digest_word),
	.word_last   (word_last),
	.pready      (pready)
);
